/* sv/sfa_pkg.sv */
// Shared types, constants and helpers for the steering kernel.
`timescale 1ns / 1ps
package sfa_pkg;

    localparam int WORD_W        = 32;
    localparam int CFG_W         = 31;
    localparam int OP_W          = 3;
    localparam int IDX_W         = 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MUL_A_W       = WORD_W + 1;
    localparam int PROD_W        = 2 * WORD_W;
    localparam int ROOT_W        = WORD_W;
    localparam int MUL_SPLIT     = 16;

    localparam logic [CFG_W-1:0] TOP_SPEED_RST  = 31'd65536;
    localparam logic [CFG_W-1:0] PREDICT_RST    = 31'd65536;
    localparam logic [CFG_W-1:0] SLOW_DIST_RST  = 31'd655360;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_SEEK    = 3'd0,
        OP_FLEE    = 3'd1,
        OP_PURSUIT = 3'd2,
        OP_EVASION = 3'd3,
        OP_ARRIVAL = 3'd4
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        REG_TOP_SPEED  = 2'd0,
        REG_PREDICTION = 2'd1,
        REG_SLOW_DIST  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic predict;
        logic away;
        logic arrive;
    } mode_t;

    localparam logic signed [PROD_W-1:0] WORD_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] WORD_LO = -64'sh0000_0000_8000_0000;

    function automatic word_t sat_word(input logic signed [PROD_W-1:0] v);
        word_t r;
        if (v > WORD_HI)
            r = WORD_HI[WORD_W-1:0];
        else if (v < WORD_LO)
            r = WORD_LO[WORD_W-1:0];
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage

/* sv/sfa_mul.sv */
// Two-stage signed by unsigned multiplier, split into two partial products.
`timescale 1ns / 1ps
module sfa_mul #(
    parameter int TW = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 valid_in,
    input  logic signed [sfa_pkg::MUL_A_W-1:0]   a,
    input  logic [sfa_pkg::CFG_W-1:0]            b,
    input  logic [TW-1:0]                        tag_in,
    output logic                                 valid_out,
    output logic signed [sfa_pkg::PROD_W-1:0]    prod,
    output logic [TW-1:0]                        tag_out
);
    import sfa_pkg::*;

    localparam int HI_W = CFG_W - MUL_SPLIT;

    logic                               v1_reg;
    logic signed [MUL_A_W+MUL_SPLIT:0]  plo_reg;
    logic signed [MUL_A_W+HI_W:0]       phi_reg;
    logic [TW-1:0]                      t1_reg;
    logic signed [PROD_W-1:0]           prod_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            valid_out <= 1'b0;
        end
        else
        begin
            v1_reg    <= valid_in;
            valid_out <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg <= a * $signed({1'b0, b[MUL_SPLIT-1:0]});
        phi_reg <= a * $signed({1'b0, b[CFG_W-1:MUL_SPLIT]});
        t1_reg  <= tag_in;
        prod    <= prod_next;
        tag_out <= t1_reg;
    end

    assign prod_next = PROD_W'(plo_reg) + (PROD_W'(phi_reg) <<< MUL_SPLIT);

endmodule

/* sv/sfa_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module sfa_sqrt #(
    parameter int RT = sfa_pkg::ROOT_W,
    parameter int TW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  logic [2*RT-1:0]   radicand,
    input  logic [TW-1:0]     tag_in,
    output logic              valid_out,
    output logic [RT-1:0]     root,
    output logic [TW-1:0]     tag_out
);
    localparam int VW = 2 * RT;

    logic [VW-1:0] rem_reg   [RT-1];
    logic [RT-1:0] root_reg  [RT];
    logic          valid_reg [RT];
    logic [TW-1:0] tag_reg   [RT];

    for (genvar k = 0; k < RT; k++)
    begin : g_stage
        localparam int B = RT - 1 - k;
        logic [VW-1:0] rem_in;
        logic [RT-1:0] root_in;
        logic          v_in;
        logic [TW-1:0] t_in;
        logic [VW:0]   trial;
        logic          ge;
        logic [RT-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
            assign v_in    = valid_in;
            assign t_in    = tag_in;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign v_in    = valid_reg[k-1];
            assign t_in    = tag_reg[k-1];
        end

        assign trial     = ((VW+1)'(root_in) << (B + 1)) + ((VW+1)'(1) << (2 * B));
        assign ge        = {1'b0, rem_in} >= trial;
        assign root_next = ge ? (root_in | (RT'(1) << B)) : root_in;

        if (k < RT - 1)
        begin : g_rem
            logic [VW-1:0] rem_next;
            assign rem_next = ge ? VW'({1'b0, rem_in} - trial) : rem_in;
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            root_reg[k] <= root_next;
            tag_reg[k]  <= t_in;
        end
    end

    assign valid_out = valid_reg[RT-1];
    assign root      = root_reg[RT-1];
    assign tag_out   = tag_reg[RT-1];

endmodule

/* sv/sfa_div.sv */
// Pipelined restoring divider, one quotient bit per stage; quotient must fit QW bits.
`timescale 1ns / 1ps
module sfa_div #(
    parameter int DW = 32,
    parameter int QW = 31,
    parameter int TW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  logic [DW+QW-1:0]   num,
    input  logic [DW-1:0]      den,
    input  logic [TW-1:0]      tag_in,
    output logic               valid_out,
    output logic [QW-1:0]      quo,
    output logic [TW-1:0]      tag_out
);
    localparam int RW = DW + QW;

    logic [RW-1:0] rem_reg   [QW-1];
    logic [DW-1:0] den_reg   [QW-1];
    logic [QW-1:0] quo_reg   [QW];
    logic          valid_reg [QW];
    logic [TW-1:0] tag_reg   [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int B = QW - 1 - k;
        logic [RW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic          v_in;
        logic [TW-1:0] t_in;
        logic [RW-1:0] shifted;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign v_in   = valid_in;
            assign t_in   = tag_in;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign v_in   = valid_reg[k-1];
            assign t_in   = tag_reg[k-1];
        end

        assign shifted = RW'(den_in) << B;
        assign ge      = rem_in >= shifted;

        if (k < QW - 1)
        begin : g_rem
            logic [RW-1:0] rem_next;
            assign rem_next = ge ? (rem_in - shifted) : rem_in;
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            quo_reg[k] <= {quo_in[QW-2:0], ge};
            tag_reg[k] <= t_in;
        end
    end

    assign valid_out = valid_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign tag_out   = tag_reg[QW-1];

endmodule

/* sv/steering_seek_flee_arrive.sv */
// Steering kernel (seek, flee, pursuit, evasion, arrival): result comes out with done.
// Throughput one item per clock; busy stays low, every start is taken.
// Most of the pipeline is the square root (32 stages) and two dividers in series (31 stages each).
// Result is shown for one cycle with done; the receiver cannot stall.
// Async reset clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
module steering_seek_flee_arrive #(
    parameter int FRAC_BITS = sfa_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [sfa_pkg::OP_W-1:0]              op,
    input  logic signed [sfa_pkg::WORD_W-1:0]     own_pos_x,
    input  logic signed [sfa_pkg::WORD_W-1:0]     own_pos_y,
    input  logic signed [sfa_pkg::WORD_W-1:0]     own_vel_x,
    input  logic signed [sfa_pkg::WORD_W-1:0]     own_vel_y,
    input  logic signed [sfa_pkg::WORD_W-1:0]     target_pos_x,
    input  logic signed [sfa_pkg::WORD_W-1:0]     target_pos_y,
    input  logic signed [sfa_pkg::WORD_W-1:0]     target_vel_x,
    input  logic signed [sfa_pkg::WORD_W-1:0]     target_vel_y,
    input  logic                                  cfg_wr,
    input  logic [sfa_pkg::IDX_W-1:0]             cfg_addr,
    input  logic [sfa_pkg::CFG_W-1:0]             cfg_data,
    output logic                                  done,
    output logic signed [sfa_pkg::WORD_W-1:0]     steer_x,
    output logic signed [sfa_pkg::WORD_W-1:0]     steer_y
);
    import sfa_pkg::*;

    localparam int LATENCY = 106;

    typedef struct packed {
        mode_t mode;
        word_t px, py, vx, vy, tx, ty;
    } t1_t;

    typedef struct packed {
        logic  arrive;
        word_t dx, dy, vx, vy;
    } t2_t;

    typedef struct packed {
        logic              byp;
        logic [ROOT_W-1:0] len;
        word_t             dx, dy, vx, vy;
    } t3_t;

    typedef struct packed {
        logic              neg_x, neg_y, zero;
        logic [ROOT_W-1:0] len;
        word_t             vx, vy;
    } t4_t;

    typedef struct packed {
        logic  neg_x, neg_y, zero;
        word_t vx, vy;
    } t5_t;

    // configuration registers
    logic [CFG_W-1:0] top_speed_reg, predict_reg, slow_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_speed_reg <= TOP_SPEED_RST;
            predict_reg   <= PREDICT_RST;
            slow_dist_reg <= SLOW_DIST_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_TOP_SPEED:  top_speed_reg <= cfg_data;
                REG_PREDICTION: predict_reg   <= cfg_data;
                REG_SLOW_DIST:  slow_dist_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign busy = 1'b0;

    // input stage
    logic  in_valid_reg;
    mode_t in_mode_reg;
    word_t in_px_reg, in_py_reg, in_vx_reg, in_vy_reg;
    word_t in_tx_reg, in_ty_reg, in_tvx_reg, in_tvy_reg;
    mode_t mode_next;

    always_comb
    begin
        mode_next.predict = (op == OP_PURSUIT) || (op == OP_EVASION);
        mode_next.away    = (op == OP_FLEE) || (op == OP_EVASION);
        mode_next.arrive  = (op == OP_ARRIVAL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_mode_reg <= mode_next;
        in_px_reg   <= own_pos_x;
        in_py_reg   <= own_pos_y;
        in_vx_reg   <= own_vel_x;
        in_vy_reg   <= own_vel_y;
        in_tx_reg   <= target_pos_x;
        in_ty_reg   <= target_pos_y;
        in_tvx_reg  <= target_vel_x;
        in_tvy_reg  <= target_vel_y;
    end

    // look-ahead offset: target velocity times prediction time
    t1_t                      t1_in, t1_out;
    logic                     m1_valid;
    logic signed [PROD_W-1:0] pv_x, pv_y;

    assign t1_in = '{mode: in_mode_reg, px: in_px_reg, py: in_py_reg, vx: in_vx_reg,
                     vy: in_vy_reg, tx: in_tx_reg, ty: in_ty_reg};

    sfa_mul #(.TW($bits(t1_t))) u_mul_pred_x (
        .clk(clk), .rst_n(rst_n), .valid_in(in_valid_reg),
        .a(MUL_A_W'(in_tvx_reg)), .b(predict_reg), .tag_in(t1_in),
        .valid_out(m1_valid), .prod(pv_x), .tag_out(t1_out)
    );

    sfa_mul #(.TW(1)) u_mul_pred_y (
        .clk(clk), .rst_n(rst_n), .valid_in(in_valid_reg),
        .a(MUL_A_W'(in_tvy_reg)), .b(predict_reg), .tag_in(1'b0),
        .valid_out(), .prod(pv_y), .tag_out()
    );

    // aim point
    word_t off_x, off_y;
    logic  s3_valid_reg;
    mode_t s3_mode_reg;
    word_t s3_px_reg, s3_py_reg, s3_vx_reg, s3_vy_reg, s3_ax_reg, s3_ay_reg;

    assign off_x = t1_out.mode.predict ? sat_word(pv_x >>> FRAC_BITS) : '0;
    assign off_y = t1_out.mode.predict ? sat_word(pv_y >>> FRAC_BITS) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= m1_valid;
    end

    always_ff @(posedge clk)
    begin
        s3_mode_reg <= t1_out.mode;
        s3_px_reg   <= t1_out.px;
        s3_py_reg   <= t1_out.py;
        s3_vx_reg   <= t1_out.vx;
        s3_vy_reg   <= t1_out.vy;
        s3_ax_reg   <= sat_word(PROD_W'(t1_out.tx) + PROD_W'(off_x));
        s3_ay_reg   <= sat_word(PROD_W'(t1_out.ty) + PROD_W'(off_y));
    end

    // direction vector
    logic  s4_valid_reg;
    mode_t s4_mode_reg;
    word_t s4_dx_reg, s4_dy_reg, s4_vx_reg, s4_vy_reg;
    word_t dx_next, dy_next;

    always_comb
    begin
        if (s3_mode_reg.away)
        begin
            dx_next = sat_word(PROD_W'(s3_px_reg) - PROD_W'(s3_ax_reg));
            dy_next = sat_word(PROD_W'(s3_py_reg) - PROD_W'(s3_ay_reg));
        end
        else
        begin
            dx_next = sat_word(PROD_W'(s3_ax_reg) - PROD_W'(s3_px_reg));
            dy_next = sat_word(PROD_W'(s3_ay_reg) - PROD_W'(s3_py_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_mode_reg <= s3_mode_reg;
        s4_dx_reg   <= dx_next;
        s4_dy_reg   <= dy_next;
        s4_vx_reg   <= s3_vx_reg;
        s4_vy_reg   <= s3_vy_reg;
    end

    // squares of the component magnitudes
    logic signed [WORD_W:0] dx_e, dy_e;
    logic [WORD_W-1:0]      mag_x, mag_y;
    logic                   s5_valid_reg;
    mode_t                  s5_mode_reg;
    word_t                  s5_dx_reg, s5_dy_reg, s5_vx_reg, s5_vy_reg;
    logic [PROD_W-1:0]      s5_sqx_reg, s5_sqy_reg;

    assign dx_e  = (WORD_W+1)'(s4_dx_reg);
    assign dy_e  = (WORD_W+1)'(s4_dy_reg);
    assign mag_x = dx_e[WORD_W] ? WORD_W'(-dx_e) : WORD_W'(dx_e);
    assign mag_y = dy_e[WORD_W] ? WORD_W'(-dy_e) : WORD_W'(dy_e);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_mode_reg <= s4_mode_reg;
        s5_dx_reg   <= s4_dx_reg;
        s5_dy_reg   <= s4_dy_reg;
        s5_vx_reg   <= s4_vx_reg;
        s5_vy_reg   <= s4_vy_reg;
        s5_sqx_reg  <= PROD_W'(mag_x) * PROD_W'(mag_x);
        s5_sqy_reg  <= PROD_W'(mag_y) * PROD_W'(mag_y);
    end

    // sum of squares
    logic              s6_valid_reg;
    t2_t               s6_tag_reg;
    logic [PROD_W-1:0] s6_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s6_tag_reg <= '{arrive: s5_mode_reg.arrive, dx: s5_dx_reg, dy: s5_dy_reg,
                        vx: s5_vx_reg, vy: s5_vy_reg};
        s6_sum_reg <= s5_sqx_reg + s5_sqy_reg;
    end

    // distance
    logic              sq_valid;
    logic [ROOT_W-1:0] len;
    t2_t               t2_out;

    sfa_sqrt #(.RT(ROOT_W), .TW($bits(t2_t))) u_sqrt (
        .clk(clk), .rst_n(rst_n), .valid_in(s6_valid_reg), .radicand(s6_sum_reg),
        .tag_in(s6_tag_reg), .valid_out(sq_valid), .root(len), .tag_out(t2_out)
    );

    // arrival ramp: top speed * len / slowing_distance, only needed below top speed
    t3_t                      t3_in, t3_out;
    logic                     m2_valid;
    logic signed [PROD_W-1:0] p_ramp;

    assign t3_in = '{byp: !t2_out.arrive || (len >= ROOT_W'(slow_dist_reg)),
                     len: len, dx: t2_out.dx, dy: t2_out.dy,
                     vx: t2_out.vx, vy: t2_out.vy};

    sfa_mul #(.TW($bits(t3_t))) u_mul_ramp (
        .clk(clk), .rst_n(rst_n), .valid_in(sq_valid),
        .a(MUL_A_W'(len)), .b(top_speed_reg), .tag_in(t3_in),
        .valid_out(m2_valid), .prod(p_ramp), .tag_out(t3_out)
    );

    logic             da_valid;
    logic [CFG_W-1:0] ramp;
    t3_t              t3_div;

    sfa_div #(.DW(CFG_W), .QW(CFG_W), .TW($bits(t3_t))) u_div_ramp (
        .clk(clk), .rst_n(rst_n), .valid_in(m2_valid),
        .num((2*CFG_W)'(p_ramp)), .den(slow_dist_reg), .tag_in(t3_out),
        .valid_out(da_valid), .quo(ramp), .tag_out(t3_div)
    );

    // scale direction to speed
    logic [CFG_W-1:0]       speed;
    logic signed [WORD_W:0] sdx_e, sdy_e;
    logic [WORD_W:0]        smag_x, smag_y;
    t4_t                    t4_in, t4_out;
    logic                   m3_valid;
    logic signed [PROD_W-1:0] p_sx, p_sy;

    assign speed  = t3_div.byp ? top_speed_reg : ramp;
    assign sdx_e  = (WORD_W+1)'(t3_div.dx);
    assign sdy_e  = (WORD_W+1)'(t3_div.dy);
    assign smag_x = sdx_e[WORD_W] ? -sdx_e : sdx_e;
    assign smag_y = sdy_e[WORD_W] ? -sdy_e : sdy_e;
    assign t4_in  = '{neg_x: t3_div.dx[WORD_W-1], neg_y: t3_div.dy[WORD_W-1],
                      zero: (t3_div.len == '0), len: t3_div.len,
                      vx: t3_div.vx, vy: t3_div.vy};

    sfa_mul #(.TW($bits(t4_t))) u_mul_scale_x (
        .clk(clk), .rst_n(rst_n), .valid_in(da_valid),
        .a($signed(smag_x)), .b(speed), .tag_in(t4_in),
        .valid_out(m3_valid), .prod(p_sx), .tag_out(t4_out)
    );

    sfa_mul #(.TW(1)) u_mul_scale_y (
        .clk(clk), .rst_n(rst_n), .valid_in(da_valid),
        .a($signed(smag_y)), .b(speed), .tag_in(1'b0),
        .valid_out(), .prod(p_sy), .tag_out()
    );

    logic             ds_valid;
    logic [CFG_W-1:0] q_x, q_y;
    t5_t              t5_in, t5_out;

    assign t5_in = '{neg_x: t4_out.neg_x, neg_y: t4_out.neg_y, zero: t4_out.zero,
                     vx: t4_out.vx, vy: t4_out.vy};

    sfa_div #(.DW(ROOT_W), .QW(CFG_W), .TW($bits(t5_t))) u_div_scale_x (
        .clk(clk), .rst_n(rst_n), .valid_in(m3_valid),
        .num((ROOT_W+CFG_W)'(p_sx)), .den(t4_out.len), .tag_in(t5_in),
        .valid_out(ds_valid), .quo(q_x), .tag_out(t5_out)
    );

    sfa_div #(.DW(ROOT_W), .QW(CFG_W), .TW(1)) u_div_scale_y (
        .clk(clk), .rst_n(rst_n), .valid_in(m3_valid),
        .num((ROOT_W+CFG_W)'(p_sy)), .den(t4_out.len), .tag_in(1'b0),
        .valid_out(), .quo(q_y), .tag_out()
    );

    // steering = desired - own velocity
    logic signed [PROD_W-1:0] des_x, des_y;

    always_comb
    begin
        if (t5_out.zero)
        begin
            des_x = '0;
            des_y = '0;
        end
        else
        begin
            des_x = t5_out.neg_x ? -PROD_W'(q_x) : PROD_W'(q_x);
            des_y = t5_out.neg_y ? -PROD_W'(q_y) : PROD_W'(q_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= ds_valid;
    end

    always_ff @(posedge clk)
    begin
        steer_x <= sat_word(des_x - PROD_W'(t5_out.vx));
        steer_y <= sat_word(des_y - PROD_W'(t5_out.vy));
    end

`ifndef SYNTH
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("done without a start LATENCY cycles earlier");

    a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
        da_valid |-> (speed <= top_speed_reg))
        else $error("arrival speed above top speed");

    a_scale_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ds_valid && !t5_out.zero |-> (q_x <= top_speed_reg) && (q_y <= top_speed_reg))
        else $error("desired velocity component above top speed");
`endif

endmodule

/* sim/tb_steering_seek_flee_arrive.sv */
// Self-checking testbench for the steering kernel: directed and random items, all modes.
`timescale 1ns / 1ps
module tb_steering_seek_flee_arrive;
    import sfa_pkg::*;

    localparam int LATENCY   = 106;
    localparam int WDOG_MAX  = 20000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [OP_W-1:0] op;
    logic signed [WORD_W-1:0] own_pos_x, own_pos_y, own_vel_x, own_vel_y;
    logic signed [WORD_W-1:0] target_pos_x, target_pos_y, target_vel_x, target_vel_y;
    logic cfg_wr;
    logic [IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_data;
    logic done;
    logic signed [WORD_W-1:0] steer_x, steer_y;

    steering_seek_flee_arrive uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .own_pos_x(own_pos_x), .own_pos_y(own_pos_y),
        .own_vel_x(own_vel_x), .own_vel_y(own_vel_y),
        .target_pos_x(target_pos_x), .target_pos_y(target_pos_y),
        .target_vel_x(target_vel_x), .target_vel_y(target_vel_y),
        .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .done(done), .steer_x(steer_x), .steer_y(steer_y)
    );

    typedef struct packed {
        logic [OP_W-1:0] mode;
        logic signed [WORD_W-1:0] px, py, vx, vy, tx, ty, tvx, tvy;
    } agent_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] sx, sy;
    } steer_t;

    steer_t steer_expected[$];
    longint unsigned speed_cap, look_ahead, slow_dist;
    int mismatches;
    int items_sent;
    int results_seen;
    int wdog;
    int send_idle_pct;
    bit [4:0] modes_seen;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint clamp_word(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // floor(a*b / 2^16), saturated
    function automatic longint fixed_mul(longint a, longint unsigned b);
        longint p;
        longint q;
        p = a * longint'(b);
        if (p >= 0)
            q = p >>> 16;
        else
            q = -((-p + 65535) >>> 16);
        return clamp_word(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs_val(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint scale_dir(longint d, longint unsigned spd, longint unsigned len);
        longint unsigned q;
        q = (abs_val(d) * spd) / len;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic steer_t predict_steer(agent_t a);
        logic predict;
        logic away;
        longint ax, ay, dx, dy, sx, sy;
        longint unsigned len, spd, ramp;
        steer_t r;
        predict = (a.mode == OP_PURSUIT) || (a.mode == OP_EVASION);
        away = (a.mode == OP_FLEE) || (a.mode == OP_EVASION);
        ax = a.tx;
        ay = a.ty;
        spd = speed_cap;
        if (predict)
        begin
            ax = clamp_word(longint'(a.tx) + fixed_mul(a.tvx, look_ahead));
            ay = clamp_word(longint'(a.ty) + fixed_mul(a.tvy, look_ahead));
        end
        if (away)
        begin
            dx = clamp_word(longint'(a.px) - ax);
            dy = clamp_word(longint'(a.py) - ay);
        end
        else
        begin
            dx = clamp_word(ax - longint'(a.px));
            dy = clamp_word(ay - longint'(a.py));
        end
        len = int_sqrt(abs_val(dx) * abs_val(dx) + abs_val(dy) * abs_val(dy));
        if (a.mode == OP_ARRIVAL && slow_dist != 0)
        begin
            ramp = (speed_cap * len) / slow_dist;
            if (ramp < spd)
                spd = ramp;
        end
        if (len == 0)
        begin
            sx = 0;
            sy = 0;
        end
        else
        begin
            sx = scale_dir(dx, spd, len);
            sy = scale_dir(dy, spd, len);
        end
        r.sx = clamp_word(sx - longint'(a.vx));
        r.sy = clamp_word(sy - longint'(a.vy));
        return r;
    endfunction

    // result checker and watchdog
    always @(posedge clk)
    begin
        steer_t exp_r;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (done)
            begin
                results_seen <= results_seen + 1;
                if (steer_expected.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result %h %h", steer_x, steer_y);
                end
                else
                begin
                    exp_r = steer_expected.pop_front();
                    if (exp_r.sx !== steer_x || exp_r.sy !== steer_y)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: exp x=%h y=%h got x=%h y=%h",
                                     exp_r.sx, exp_r.sy, steer_x, steer_y);
                    end
                end
            end
            if (wdog >= WDOG_MAX)
            begin
                $display("watchdog expired");
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // start stays high after the accepting edge; the next send or drain sets it
    task automatic send_agent(agent_t a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op <= a.mode;
        own_pos_x <= a.px;
        own_pos_y <= a.py;
        own_vel_x <= a.vx;
        own_vel_y <= a.vy;
        target_pos_x <= a.tx;
        target_pos_y <= a.ty;
        target_vel_x <= a.tvx;
        target_vel_y <= a.tvy;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        steer_expected.push_back(predict_steer(a));
        if (a.mode < 5)
            modes_seen[a.mode] = 1'b1;
        items_sent = items_sent + 1;
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        while (steer_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, longint unsigned val);
        cfg_wr <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[CFG_W-1:0];
        @(posedge clk);
        cfg_wr <= 1'b0;
        case (idx)
            REG_TOP_SPEED:  speed_cap = val & 64'h7FFF_FFFF;
            REG_PREDICTION: look_ahead = val & 64'h7FFF_FFFF;
            REG_SLOW_DIST:  slow_dist = val & 64'h7FFF_FFFF;
            default:        ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic signed [WORD_W-1:0] rand_coord(int kind);
        logic signed [WORD_W-1:0] v;
        case (kind)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            2: v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: v = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
        return v;
    endfunction

    function automatic agent_t rand_agent();
        agent_t a;
        int k;
        k = ($urandom_range(9) < 7) ? $urandom_range(1, 3) : $urandom_range(0, 2);
        a.mode = ($urandom_range(19) == 0) ? OP_W'($urandom_range(5, 7))
                                           : OP_W'($urandom_range(0, 4));
        a.px = rand_coord(k);
        a.py = rand_coord(k);
        a.vx = rand_coord(k);
        a.vy = rand_coord(k);
        a.tx = rand_coord(k);
        a.ty = rand_coord(k);
        a.tvx = rand_coord(k);
        a.tvy = rand_coord(k);
        // sometimes put the target right on the agent to hit zero distance
        if ($urandom_range(15) == 0)
        begin
            a.tx = a.px;
            a.ty = a.py;
            a.tvx = 0;
            a.tvy = 0;
        end
        return a;
    endfunction

    task automatic test_directed();
        agent_t a;
        a = '0;
        for (int m = 0; m < 8; m++)
        begin
            a = '0;
            a.mode = OP_W'(m);
            a.tx = 32'sh0003_0000;
            a.ty = -32'sh0004_0000;
            a.tvx = 32'sh0001_8000;
            a.tvy = -32'sh0000_4000;
            a.vx = 32'sh0000_1000;
            send_agent(a);
        end
        a = '0;
        a.mode = OP_SEEK;
        a.vx = 32'sh7FFF_FFFF;
        a.vy = 32'sh8000_0000;
        send_agent(a);
        a.mode = OP_ARRIVAL;
        send_agent(a);
        a = '1;
        a.mode = OP_FLEE;
        send_agent(a);
        a.px = 32'sh8000_0000;
        a.py = 32'sh8000_0000;
        a.tx = 32'sh7FFF_FFFF;
        a.ty = 32'sh7FFF_FFFF;
        a.vx = 32'sh8000_0000;
        a.vy = 32'sh7FFF_FFFF;
        for (int m = 0; m < 5; m++)
        begin
            a.mode = OP_W'(m);
            a.tvx = 32'sh7FFF_FFFF;
            a.tvy = 32'sh8000_0000;
            send_agent(a);
        end
        a = '0;
        a.mode = OP_ARRIVAL;
        a.tx = 32'sh0000_8000;
        send_agent(a);
        a.tx = 32'sh0100_0000;
        send_agent(a);
        drain_pipe();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_agent(rand_agent());
        drain_pipe();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_TOP_SPEED, 64'h7FFF_FFFF);
        write_reg(REG_PREDICTION, 0);
        write_reg(REG_SLOW_DIST, 1);
        test_random(150);
        write_reg(REG_TOP_SPEED, 0);
        write_reg(REG_PREDICTION, 64'h7FFF_FFFF);
        write_reg(REG_SLOW_DIST, 64'h7FFF_FFFF);
        test_random(150);
        write_reg(REG_TOP_SPEED, $urandom);
        write_reg(REG_PREDICTION, $urandom_range(0, 32'h0004_0000));
        write_reg(REG_SLOW_DIST, $urandom_range(1, 32'h0100_0000));
        test_random(200);
        write_reg(REG_TOP_SPEED, 32'h0002_0000);
        write_reg(REG_PREDICTION, 32'h0000_8000);
        write_reg(REG_SLOW_DIST, 32'h0040_0000);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        op = '0;
        own_pos_x = '0; own_pos_y = '0; own_vel_x = '0; own_vel_y = '0;
        target_pos_x = '0; target_pos_y = '0; target_vel_x = '0; target_vel_y = '0;
        cfg_wr = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        wdog = 0;
        modes_seen = '0;
        send_idle_pct = 20;
        speed_cap = 65536;
        look_ahead = 65536;
        slow_dist = 655360;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(300);
        send_idle_pct = 86;
        test_config_extremes();
        send_idle_pct = 0;
        test_random(700);

        repeat (LATENCY + 20) @(posedge clk);
        $display("covered %0d items over all five modes (mask %b), %0d results checked",
                 items_sent, modes_seen, results_seen);
        $display("register extremes and several mid settings, three idle patterns");
        if (mismatches == 0 && steer_expected.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
